[rtl/nps_pkg.sv]
// Shared constants, types and helpers for the nearest palette colour search block.
package nps_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int INDEX_REACH   = 256;
    localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int IDX_W         = 8;
    localparam int COUNT_W       = 9;
    localparam int COLOR_W       = 32;
    localparam int SQ_W          = 16;
    localparam int DIST_W        = 18;

    localparam logic [COUNT_W-1:0] SCAN_LIMIT =
        COUNT_W'((PALETTE_DEPTH < INDEX_REACH) ? PALETTE_DEPTH : INDEX_REACH);

    localparam logic [COLOR_W-1:0] BYTE_PAIR_MASK = 32'h00ff00ff;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [7:0] t_byte;
    typedef t_byte [3:0] t_lanes;
    typedef logic [SQ_W-1:0] t_sq;

    typedef struct packed {
        logic wr_en;
        logic start;
        logic scan_en;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_query;
        logic count_zero;
        logic scan_last;
        logic busy;
        logic out_free;
    } t_dp_status;

    // Split into even and odd byte pairs.
    function automatic t_lanes split_lanes(input logic [COLOR_W-1:0] c);
        logic [COLOR_W-1:0] ev;
        logic [COLOR_W-1:0] od;
        t_lanes l;
        ev = c & BYTE_PAIR_MASK;
        od = (c >> 8) & BYTE_PAIR_MASK;
        l[0] = ev[7:0];
        l[1] = od[7:0];
        l[2] = ev[23:16];
        l[3] = od[23:16];
        return l;
    endfunction

    function automatic t_sq byte_sq(input t_byte a, input t_byte b);
        t_byte d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

[rtl/nps_in_if.sv]
// Input item channel: palette writes and search queries.
interface nps_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  entry_index;
    logic [31:0] entry_color;
    logic [31:0] wanted_color;
    logic [8:0]  search_count;

    modport source (output valid, action, entry_index, entry_color, wanted_color,
                    search_count, input ready);
    modport sink   (input valid, action, entry_index, entry_color, wanted_color,
                    search_count, output ready);
endinterface

[rtl/nps_out_if.sv]
// Result item channel: nearest index and distance.
interface nps_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  nearest_index;
    logic [17:0] nearest_distance;

    modport source (output valid, nearest_index, nearest_distance, input ready);
    modport sink   (input valid, nearest_index, nearest_distance, output ready);
endinterface

[rtl/nearest_palette_color_search_unit.sv]
// Top level of the nearest palette colour search block.
//
// Input channel i_in carries one item per handshake. action 0 writes entry_color
// to palette slot entry_index (ignored when beyond the palette) and yields no result.
// action 1 searches entries 0 to search_count-1 (clamped to 256) for the smallest
// sum of squared byte differences to wanted_color, lowest index on ties; a count
// of zero yields no result. Output channel o_out returns nearest_index and
// nearest_distance for each search.
// A write is stored as it is accepted. A search occupies the block for the
// accepting cycle, one palette read per cycle from the single-port store,
// a two-stage square and compare pipeline drain, then the result load.
// The result sits in an output register; writes are taken while it waits, and a
// following search scans fully but holds before loading until the register frees.
// Reset clears the control state and the output valid; palette contents stay
// undefined until written.
module nearest_palette_color_search_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nps_in_if.sink    i_in,
    nps_out_if.source o_out
);
    import nps_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    nps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    nps_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_action           (i_in.action),
        .i_entry_index      (i_in.entry_index),
        .i_entry_color      (i_in.entry_color),
        .i_wanted_color     (i_in.wanted_color),
        .i_search_count     (i_in.search_count),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_nearest_index    (o_out.nearest_index),
        .o_nearest_distance (o_out.nearest_distance)
    );

endmodule

[rtl/nps_ctrl.sv]
// Control state machine sequencing writes, palette scans and result loading.
module nps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  nps_pkg::t_dp_status i_status,
    output nps_pkg::t_ctrl_cmd  o_cmd
);
    import nps_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.wr_en   = accept && !i_status.is_query;
        o_cmd.start   = accept && i_status.is_query && !i_status.count_zero;
        o_cmd.scan_en = (r_state == S_SCAN);
        o_cmd.load    = (r_state == S_FINISH) && !i_status.busy && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (o_cmd.load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/nps_datapath.sv]
// Palette memory, distance pipeline, running minimum and result register.
module nps_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nps_pkg::t_ctrl_cmd  i_cmd,
    output nps_pkg::t_dp_status o_status,
    input  logic                i_action,
    input  logic [7:0]          i_entry_index,
    input  logic [31:0]         i_entry_color,
    input  logic [31:0]         i_wanted_color,
    input  logic [8:0]          i_search_count,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_nearest_index,
    output logic [17:0]         o_nearest_distance
);
    import nps_pkg::*;

    logic [COLOR_W-1:0] r_mem [PALETTE_DEPTH];

    logic [COLOR_W-1:0] r_wanted;
    logic [COUNT_W-1:0] r_limit;
    logic [COUNT_W-1:0] r_idx;

    logic               r_rd_valid;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [COLOR_W-1:0] r_rd_data;

    logic               r_sq_valid;
    logic [IDX_W-1:0]   r_sq_idx;
    t_sq [3:0]          r_sq;

    logic [IDX_W-1:0]   r_best_idx;
    logic [DIST_W-1:0]  r_best_dist;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic [DIST_W-1:0]  r_out_dist;

    logic               in_range;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COUNT_W-1:0] clamped;
    t_lanes             lanes_p;
    t_lanes             lanes_w;
    logic [DIST_W-1:0]  cand_dist;

    assign in_range = (32'(i_entry_index) < 32'(PALETTE_DEPTH));
    assign wr_addr  = ADDR_W'(i_entry_index);
    assign rd_addr  = ADDR_W'(r_idx[IDX_W-1:0]);
    assign clamped  = (i_search_count > SCAN_LIMIT) ? SCAN_LIMIT : i_search_count;
    assign lanes_p  = split_lanes(r_rd_data);
    assign lanes_w  = split_lanes(r_wanted);
    assign cand_dist = DIST_W'(r_sq[0]) + DIST_W'(r_sq[1])
                     + DIST_W'(r_sq[2]) + DIST_W'(r_sq[3]);

    always_comb begin
        o_status.is_query   = (i_action == ACT_QUERY);
        o_status.count_zero = (i_search_count == '0);
        o_status.scan_last  = (r_idx == (r_limit - COUNT_W'(1)));
        o_status.busy       = r_rd_valid || r_sq_valid;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // Palette store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && in_range) begin
            r_mem[wr_addr] <= i_entry_color;
        end
        if (i_cmd.scan_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Scan pointer and query operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_wanted <= i_wanted_color;
            r_limit  <= clamped;
            r_idx    <= '0;
        end else if (i_cmd.scan_en) begin
            r_idx <= r_idx + COUNT_W'(1);
        end
    end

    // Squares stage, running minimum and result register
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[IDX_W-1:0];
        r_sq_idx <= r_rd_idx;
        for (int k = 0; k < 4; k++) begin
            r_sq[k] <= byte_sq(lanes_p[k], lanes_w[k]);
        end
        if (r_sq_valid && ((r_sq_idx == '0) || (cand_dist < r_best_dist))) begin
            r_best_idx  <= r_sq_idx;
            r_best_dist <= cand_dist;
        end
        if (i_cmd.load) begin
            r_out_idx  <= r_best_idx;
            r_out_dist <= r_best_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_sq_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan_en;
            r_sq_valid <= r_rd_valid;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_nearest_index    = r_out_idx;
    assign o_nearest_distance = r_out_dist;

endmodule

[bench/tb.sv]
// Testbench for the nearest palette colour search unit with random writes and searches.
`timescale 1ns / 1ps

module tb;
    import nps_pkg::*;

    typedef struct {
        logic              action;
        logic [IDX_W-1:0]  entry_index;
        logic [COLOR_W-1:0] entry_color;
        logic [COLOR_W-1:0] wanted_color;
        logic [COUNT_W-1:0] search_count;
    } t_palette_op;

    typedef struct {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
    } t_nearest;

    localparam int SCAN_MAX   = (PALETTE_DEPTH < INDEX_REACH) ? PALETTE_DEPTH : INDEX_REACH;
    localparam int RAND_ITEMS = 1400;
    localparam int DRAIN_CYC  = 300;

    logic clk = 1'b0;
    logic rst_n;

    nps_in_if  in_ch ();
    nps_out_if out_ch ();

    nearest_palette_color_search_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 clk = ~clk;

    t_palette_op        op_queue[$];
    t_nearest           results_due[$];
    logic [COLOR_W-1:0] pal_mirror[PALETTE_DEPTH];
    logic [COLOR_W-1:0] gen_pal[PALETTE_DEPTH];
    bit                 gen_written[PALETTE_DEPTH];

    int n_items   = 0;
    int n_offered = 0;
    int n_taken   = 0;
    int n_fail    = 0;
    int cyc       = 0;
    int in_gap    = 0;
    int out_gap   = 0;
    bit calm;
    t_palette_op op;
    t_nearest    got;
    t_nearest    due;

    function automatic logic [DIST_W-1:0] colour_dist(input logic [COLOR_W-1:0] a,
                                                      input logic [COLOR_W-1:0] b);
        int sum;
        int da;
        int db;
        int d;
        sum = 0;
        for (int k = 0; k < 4; k++) begin
            da = int'(a[8*k +: 8]);
            db = int'(b[8*k +: 8]);
            d = (da > db) ? da - db : db - da;
            sum += d * d;
        end
        return DIST_W'(sum);
    endfunction

    function automatic t_nearest nearest_of(input logic [COLOR_W-1:0] want,
                                            input logic [COUNT_W-1:0] count);
        t_nearest best;
        int n;
        logic [DIST_W-1:0] d;
        n = (int'(count) > SCAN_MAX) ? SCAN_MAX : int'(count);
        best.index = '0;
        best.distance = colour_dist(pal_mirror[0], want);
        for (int i = 1; i < n; i++) begin
            d = colour_dist(pal_mirror[i], want);
            if (d < best.distance) begin
                best.distance = d;
                best.index = IDX_W'(i);
            end
        end
        return best;
    endfunction

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < PALETTE_DEPTH && gen_written[n])
            n++;
        return n;
    endfunction

    function automatic logic [COLOR_W-1:0] extreme_colour();
        unique case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h00ff_00ff;
            default: return 32'hff00_ff00;
        endcase
    endfunction

    // small pool so that equal colours, and hence ties, turn up often
    function automatic logic [COLOR_W-1:0] shade_colour();
        unique case ($urandom_range(0, 3))
            0: return 32'h2040_6080;
            1: return 32'h7f7f_7f7f;
            2: return 32'h8080_8080;
            default: return 32'hc0ff_0a11;
        endcase
    endfunction

    function automatic int gap_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic add_op(input logic a, input logic [IDX_W-1:0] ix,
                          input logic [COLOR_W-1:0] ec, input logic [COLOR_W-1:0] wc,
                          input logic [COUNT_W-1:0] cnt);
        t_palette_op item;
        item.action       = a;
        item.entry_index  = ix;
        item.entry_color  = ec;
        item.wanted_color = wc;
        item.search_count = cnt;
        if (a == ACT_WRITE && int'(ix) < PALETTE_DEPTH) begin
            gen_written[ix] = 1'b1;
            gen_pal[ix] = ec;
        end
        op_queue.push_back(item);
    endtask

    // driver
    always @(negedge clk) begin
        cyc++;
        if (!rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            calm = (cyc % 1500) < 300;
            if (!(in_ch.valid && n_taken < n_offered)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    op = op_queue.pop_front();
                    in_ch.action       <= op.action;
                    in_ch.entry_index  <= op.entry_index;
                    in_ch.entry_color  <= op.entry_color;
                    in_ch.wanted_color <= op.wanted_color;
                    in_ch.search_count <= op.search_count;
                    in_ch.valid        <= 1'b1;
                    n_offered++;
                    in_gap = gap_len(calm);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                out_gap = ($urandom_range(0, 99) < 30) ? gap_len(calm) : 0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                n_taken++;
                if (in_ch.action == ACT_WRITE) begin
                    if (int'(in_ch.entry_index) < PALETTE_DEPTH)
                        pal_mirror[in_ch.entry_index] = in_ch.entry_color;
                end else if (in_ch.search_count != '0) begin
                    results_due.push_back(nearest_of(in_ch.wanted_color, in_ch.search_count));
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                got.index    = out_ch.nearest_index;
                got.distance = out_ch.nearest_distance;
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, index %0d distance %0d",
                             $time, got.index, got.distance);
                    n_fail++;
                end else begin
                    due = results_due.pop_front();
                    if (got.index !== due.index) begin
                        $display("%0t: nearest_index expected %0d got %0d",
                                 $time, due.index, got.index);
                        n_fail++;
                    end
                    if (got.distance !== due.distance) begin
                        $display("%0t: nearest_distance expected %0d got %0d",
                                 $time, due.distance, got.distance);
                        n_fail++;
                    end
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int p;
        int lim;
        int r;
        logic [IDX_W-1:0]   ix;
        logic [COLOR_W-1:0] c;
        logic [COLOR_W-1:0] w;
        logic [COUNT_W-1:0] n;

        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_WRITE;
        in_ch.entry_index  = '0;
        in_ch.entry_color  = '0;
        in_ch.wanted_color = '0;
        in_ch.search_count = '0;
        out_ch.ready       = 1'b0;
        rst_n              = 1'b0;

        // directed
        add_op(ACT_WRITE, 8'd0,   32'h0000_0000, 32'hffff_ffff, 9'h1ff);
        add_op(ACT_QUERY, 8'hff,  32'hffff_ffff, 32'hffff_ffff, 9'd1);
        add_op(ACT_QUERY, 8'd0,   32'h0000_0000, 32'h1234_5678, 9'd0);
        add_op(ACT_WRITE, 8'd1,   32'hffff_ffff, 32'h0000_0000, 9'd0);
        add_op(ACT_WRITE, 8'd2,   32'h0000_0000, $urandom, 9'($urandom));
        add_op(ACT_WRITE, 8'd3,   32'h00ff_00ff, $urandom, 9'($urandom));
        add_op(ACT_WRITE, 8'd4,   32'hff00_ff00, $urandom, 9'($urandom));
        add_op(ACT_QUERY, IDX_W'($urandom), $urandom, 32'h0000_0000, 9'd5);
        add_op(ACT_QUERY, IDX_W'($urandom), $urandom, 32'hffff_ffff, 9'd5);
        add_op(ACT_QUERY, IDX_W'($urandom), $urandom, 32'h8080_8080, 9'd5);
        add_op(ACT_QUERY, IDX_W'($urandom), $urandom, 32'h00ff_00ff, 9'd4);
        add_op(ACT_QUERY, IDX_W'($urandom), $urandom, 32'h01fe_01fe, 9'd5);
        add_op(ACT_WRITE, 8'd5,   32'h1234_5678, $urandom, 9'($urandom));
        add_op(ACT_WRITE, 8'd6,   32'h1234_5678, $urandom, 9'($urandom));
        add_op(ACT_QUERY, IDX_W'($urandom), $urandom, 32'h1234_5679, 9'd7);
        add_op(ACT_WRITE, 8'hff,  32'ha5a5_a5a5, 32'hffff_ffff, 9'h1ff);
        add_op(ACT_QUERY, 8'hff,  32'hffff_ffff, 32'ha5a5_a5a5, 9'd7);
        add_op(ACT_QUERY, 8'd0,   32'h0000_0000, 32'hff00_ff00, 9'd1);

        // random: writes grow the written prefix, searches stay inside it
        for (int i = 0; i < RAND_ITEMS; i++) begin
            p = written_prefix();
            lim = (p >= SCAN_MAX) ? SCAN_MAX : p;
            if (p == 0 || $urandom_range(0, 99) < 45) begin
                if (p < PALETTE_DEPTH && $urandom_range(0, 99) < 55)
                    ix = IDX_W'(p);
                else
                    ix = IDX_W'($urandom_range(0, PALETTE_DEPTH - 1));
                r = $urandom_range(0, 99);
                if (r < 15)
                    c = shade_colour();
                else if (r < 25)
                    c = extreme_colour();
                else
                    c = $urandom;
                add_op(ACT_WRITE, ix, c, $urandom, 9'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    n = '0;
                else if (r < 38)
                    n = COUNT_W'($urandom_range(1, (lim < 8) ? lim : 8));
                else if (r < 50)
                    n = COUNT_W'(lim);
                else if (p >= SCAN_MAX && r < 70)
                    n = COUNT_W'($urandom_range(SCAN_MAX, 511));
                else
                    n = COUNT_W'($urandom_range(1, lim));
                r = $urandom_range(0, 99);
                if (r < 30)
                    w = gen_pal[$urandom_range(0, lim - 1)]
                        ^ (32'($urandom_range(0, 3)) << (8 * $urandom_range(0, 3)));
                else if (r < 45)
                    w = ($urandom_range(0, 1) == 0) ? extreme_colour() : shade_colour();
                else
                    w = $urandom;
                add_op(ACT_QUERY, IDX_W'($urandom), $urandom, w, n);
            end
        end
        n_items = op_queue.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(n_taken == n_items && results_due.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/nps_pkg.sv
rtl/nps_in_if.sv
rtl/nps_out_if.sv
rtl/nps_ctrl.sv
rtl/nps_datapath.sv
rtl/nearest_palette_color_search_unit.sv
bench/tb.sv
